[hw/rtl/ftcr_pkg.sv]
// Shared types, codes and constants of the frame table clock replacer.
package ftcr_pkg;

    localparam int MAX_FRAMES_DEF = 64;
    localparam int PAGE_BYTES_DEF = 4096;

    localparam logic [31:0] RESERVED_PAGE = 32'd1;

    localparam logic [1:0] OP_MAP   = 2'd0;
    localparam logic [1:0] OP_REL   = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;
    localparam logic [1:0] OP_UNDEF = 2'd3;

    localparam logic [2:0] ST_HIT    = 3'd0;
    localparam logic [2:0] ST_FREE   = 3'd1;
    localparam logic [2:0] ST_VICTIM = 3'd2;
    localparam logic [2:0] ST_NOTF   = 3'd3;
    localparam logic [2:0] ST_NOVIC  = 3'd4;
    localparam logic [2:0] ST_FREED  = 3'd5;

    localparam int FL_V = 0;
    localparam int FL_R = 1;
    localparam int FL_T = 2;

    localparam int          ADDR_W    = 3;
    localparam logic [2:0]  ADDR_AF   = 3'd0;
    localparam logic [2:0]  ADDR_BASE = 3'd4;
    localparam logic [6:0]  AF_RESET  = 7'd64;
    localparam logic [6:0]  CNT_MAX   = 7'd127;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] page_address;
        logic [14:0] process_id;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  frame_index;
        logic [31:0] phys_address;
        logic        evicted_valid;
        logic [31:0] evicted_page;
        logic [14:0] evicted_process;
        logic [6:0]  freed_count;
    } t_out;

    typedef struct packed {
        logic [2:0]  flags;
        logic [31:0] page;
        logic [14:0] owner;
    } t_entry;

    typedef struct packed {
        logic match;
        logic free_slot;
        logic skip;
        logic refd;
        logic valid;
        logic own;
    } t_cmp;

endpackage

[hw/rtl/ftcr_cmp.sv]
// Shared entry compare unit: classifies one table entry against the request key.
module ftcr_cmp (
    input  ftcr_pkg::t_entry i_entry,
    input  logic [31:0]      i_page,
    input  logic [14:0]      i_pid,
    output ftcr_pkg::t_cmp   o_cmp
);
    logic valid;
    logic rsvd;

    assign valid = i_entry.flags[ftcr_pkg::FL_V];
    assign rsvd  = (i_entry.page == ftcr_pkg::RESERVED_PAGE);

    always_comb begin
        o_cmp.valid     = valid;
        o_cmp.match     = valid && (i_entry.page == i_page) && (i_entry.owner == i_pid);
        o_cmp.free_slot = !valid && !rsvd;
        o_cmp.skip      = i_entry.flags[ftcr_pkg::FL_T] || rsvd;
        o_cmp.refd      = i_entry.flags[ftcr_pkg::FL_R];
        o_cmp.own       = valid && (i_entry.owner == i_pid) && !rsvd;
    end
endmodule

[hw/rtl/ftcr_mem.sv]
// Frame table memory: one write port and one registered read port.
module ftcr_mem #(
    parameter int MAX_FRAMES = ftcr_pkg::MAX_FRAMES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [$clog2(MAX_FRAMES)-1:0] i_waddr,
    input  ftcr_pkg::t_entry              i_wdata,
    input  logic                          i_re,
    input  logic [$clog2(MAX_FRAMES)-1:0] i_raddr,
    output ftcr_pkg::t_entry              o_rdata
);
    ftcr_pkg::t_entry r_mem [MAX_FRAMES];
    ftcr_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[hw/rtl/frame_table_clock_replacer.sv]
// Top level of the frame table clock replacer: sequencer, registers and output stage.
//
// Input channel (i_in_valid / o_in_ready / i_in) takes one request word: map a page,
// release a page from the TLB, or free every page of a process. The output channel
// (o_out_valid / i_out_ready / o_out) returns exactly one result word per request.
// Registers active_frames and frame_base_address sit on the APB port at 0x0 and 0x4.
//
// Map, release and free requests scan the frame table entry by entry over n entries, with
// n the active frame count: a memory read, then a compare in the shared compare unit. A
// map miss with no free frame adds a clock sweep of up to 3*n entries, each again read
// and then compared. Opcode 3 goes straight to the output stage without a scan.
// The block takes one request at a time and is not ready while one is in work.
//
// After reset the table is cleared, one entry per cycle over all MAX_FRAMES entries,
// during which no request is taken. A finished result is held in the output register
// while the receiver stalls; the block may meanwhile accept and work on the next
// request, but waits with its result until that register is free.
module frame_table_clock_replacer #(
    parameter int MAX_FRAMES = ftcr_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_BYTES = ftcr_pkg::PAGE_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ftcr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  ftcr_pkg::t_in               i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output ftcr_pkg::t_out              o_out
);
    localparam int FI_W = $clog2(MAX_FRAMES);
    localparam int CW   = FI_W + 1;
    localparam int SW   = $clog2(3 * MAX_FRAMES + 1);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_RD   = 4'd2;
    localparam logic [3:0] S_EV   = 4'd3;
    localparam logic [3:0] S_ERD  = 4'd4;
    localparam logic [3:0] S_EEV  = 4'd5;
    localparam logic [3:0] S_OUT  = 4'd6;

    logic [3:0]       r_state;
    logic [6:0]       r_af;
    logic [31:0]      r_base;
    logic [1:0]       r_op;
    logic [31:0]      r_page;
    logic [14:0]      r_pid;
    logic [CW-1:0]    r_n;
    logic [SW-1:0]    r_lim;
    logic [SW-1:0]    r_steps;
    logic [FI_W-1:0]  r_idx;
    logic [FI_W-1:0]  r_pos;
    logic [FI_W-1:0]  r_hand;
    logic             r_hit;
    logic [FI_W-1:0]  r_midx;
    ftcr_pkg::t_entry r_ment;
    logic             r_hasfree;
    logic [FI_W-1:0]  r_fidx;
    logic [2:0]       r_fflags;
    logic [6:0]       r_cnt;
    ftcr_pkg::t_out   r_res;
    logic [FI_W-1:0]  r_ridx;
    logic             r_out_valid;
    ftcr_pkg::t_out   r_out;

    logic             mem_we;
    logic [FI_W-1:0]  mem_waddr;
    ftcr_pkg::t_entry mem_wdata;
    logic             mem_re;
    logic [FI_W-1:0]  mem_raddr;
    ftcr_pkg::t_entry rd;
    ftcr_pkg::t_cmp   cmp;

    logic             in_acc;
    logic             cfg_wr;
    logic [31:0]      af32;
    logic [CW-1:0]    n_cnt;
    logic             idx_last;
    logic [FI_W-1:0]  pos_next;
    logic             eff_hit;
    logic [FI_W-1:0]  eff_midx;
    ftcr_pkg::t_entry eff_ment;
    logic             eff_free;
    logic [FI_W-1:0]  eff_fidx;
    logic [2:0]       eff_fflags;
    logic             victim;
    logic             out_free;
    logic [31:0]      out_phys;

    ftcr_mem #(.MAX_FRAMES(MAX_FRAMES)) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_re   (mem_re),
        .i_raddr(mem_raddr),
        .o_rdata(rd)
    );

    ftcr_cmp u_cmp (
        .i_entry(rd),
        .i_page (r_page),
        .i_pid  (r_pid),
        .o_cmp  (cmp)
    );

    assign pready     = 1'b1;
    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign cfg_wr     = psel && penable && pwrite;
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        case (paddr)
            ftcr_pkg::ADDR_AF:   prdata = {25'd0, r_af};
            ftcr_pkg::ADDR_BASE: prdata = r_base;
            default:             prdata = 32'd0;
        endcase
    end

    // Active frame count, clamped to 1..MAX_FRAMES.
    assign af32  = {25'd0, r_af};
    assign n_cnt = (af32 == 32'd0) ? CW'(1) :
                   (af32 > 32'(MAX_FRAMES)) ? CW'(MAX_FRAMES) : CW'(af32);

    assign idx_last = (CW'(r_idx) + CW'(1) == r_n);
    assign pos_next = (CW'(r_pos) + CW'(1) == r_n) ? '0 : FI_W'(CW'(r_pos) + CW'(1));

    // The last entry of the scan may itself be the first match or free frame.
    assign eff_hit    = r_hit || cmp.match;
    assign eff_midx   = r_hit ? r_midx : r_idx;
    assign eff_ment   = r_hit ? r_ment : rd;
    assign eff_free   = r_hasfree || cmp.free_slot;
    assign eff_fidx   = r_hasfree ? r_fidx : r_idx;
    assign eff_fflags = r_hasfree ? r_fflags : rd.flags;
    assign victim     = !cmp.skip && !cmp.refd;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = r_idx;
        case (r_state)
            S_CLR: begin
                mem_we = 1'b1;
            end
            S_RD: begin
                mem_re = 1'b1;
            end
            S_ERD: begin
                mem_re    = 1'b1;
                mem_raddr = r_pos;
            end
            S_EV: begin
                if (r_op == ftcr_pkg::OP_FREE) begin
                    mem_we = cmp.own;
                end else if (idx_last && eff_hit) begin
                    mem_we    = 1'b1;
                    mem_waddr = eff_midx;
                    mem_wdata = eff_ment;
                    if (r_op == ftcr_pkg::OP_MAP) begin
                        mem_wdata.flags[ftcr_pkg::FL_T] = 1'b1;
                    end else begin
                        mem_wdata.flags[ftcr_pkg::FL_T] = 1'b0;
                        mem_wdata.flags[ftcr_pkg::FL_R] = 1'b1;
                    end
                end else if (idx_last && eff_free && r_op == ftcr_pkg::OP_MAP) begin
                    mem_we          = 1'b1;
                    mem_waddr       = eff_fidx;
                    mem_wdata.flags = eff_fflags;
                    mem_wdata.flags[ftcr_pkg::FL_V] = 1'b1;
                    mem_wdata.flags[ftcr_pkg::FL_T] = 1'b1;
                    mem_wdata.page  = r_page;
                    mem_wdata.owner = r_pid;
                end
            end
            S_EEV: begin
                mem_waddr = r_pos;
                if (!cmp.skip) begin
                    mem_we = 1'b1;
                    if (victim) begin
                        mem_wdata.flags = rd.flags;
                        mem_wdata.flags[ftcr_pkg::FL_V] = 1'b1;
                        mem_wdata.flags[ftcr_pkg::FL_T] = 1'b1;
                        mem_wdata.page  = r_page;
                        mem_wdata.owner = r_pid;
                    end else begin
                        mem_wdata = rd;
                        mem_wdata.flags[ftcr_pkg::FL_R] = 1'b0;
                    end
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_idx       <= '0;
            r_hand      <= '0;
            r_af        <= ftcr_pkg::AF_RESET;
            r_base      <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr && paddr == ftcr_pkg::ADDR_AF) begin
                r_af <= pwdata[6:0];
            end
            if (cfg_wr && paddr == ftcr_pkg::ADDR_BASE) begin
                r_base <= pwdata;
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_CLR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == FI_W'(MAX_FRAMES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_op        <= i_in.opcode;
                        r_page      <= i_in.page_address;
                        r_pid       <= i_in.process_id;
                        r_n         <= n_cnt;
                        r_lim       <= SW'(3) * SW'(n_cnt);
                        r_idx       <= '0;
                        r_hit       <= 1'b0;
                        r_hasfree   <= 1'b0;
                        r_cnt       <= '0;
                        r_res       <= {ftcr_pkg::ST_NOTF, {($bits(ftcr_pkg::t_out) - 3){1'b0}}};
                        r_ridx      <= '0;
                        if (i_in.opcode == ftcr_pkg::OP_MAP || i_in.opcode == ftcr_pkg::OP_REL
                                || i_in.opcode == ftcr_pkg::OP_FREE) begin
                            r_state <= S_RD;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_EV;
                end
                S_EV: begin
                    if (cmp.match && !r_hit) begin
                        r_hit  <= 1'b1;
                        r_midx <= r_idx;
                        r_ment <= rd;
                    end
                    if (cmp.free_slot && !r_hasfree) begin
                        r_hasfree <= 1'b1;
                        r_fidx    <= r_idx;
                        r_fflags  <= rd.flags;
                    end
                    if (r_op == ftcr_pkg::OP_FREE && cmp.own && r_cnt != ftcr_pkg::CNT_MAX) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (!idx_last) begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_RD;
                    end else if (r_op == ftcr_pkg::OP_FREE) begin
                        r_res.status      <= ftcr_pkg::ST_FREED;
                        r_res.freed_count <= (cmp.own && r_cnt != ftcr_pkg::CNT_MAX) ?
                                             r_cnt + 1'b1 : r_cnt;
                        r_state           <= S_OUT;
                    end else if (eff_hit) begin
                        r_res.status <= ftcr_pkg::ST_HIT;
                        r_ridx       <= eff_midx;
                        r_state      <= S_OUT;
                    end else if (r_op == ftcr_pkg::OP_REL) begin
                        r_state <= S_OUT;
                    end else if (eff_free) begin
                        r_res.status <= ftcr_pkg::ST_FREE;
                        r_ridx       <= eff_fidx;
                        r_state      <= S_OUT;
                    end else begin
                        r_pos   <= (CW'(r_hand) < r_n) ? r_hand : '0;
                        r_steps <= '0;
                        r_state <= S_ERD;
                    end
                end
                S_ERD: begin
                    r_state <= S_EEV;
                end
                S_EEV: begin
                    if (victim) begin
                        r_res.status <= ftcr_pkg::ST_VICTIM;
                        r_ridx       <= r_pos;
                        r_hand       <= pos_next;
                        if (cmp.valid) begin
                            r_res.evicted_valid   <= 1'b1;
                            r_res.evicted_page    <= rd.page;
                            r_res.evicted_process <= rd.owner;
                        end
                        r_state <= S_OUT;
                    end else begin
                        r_pos   <= pos_next;
                        r_steps <= r_steps + 1'b1;
                        if (r_steps + SW'(1) == r_lim) begin
                            r_res.status <= ftcr_pkg::ST_NOVIC;
                            r_state      <= S_OUT;
                        end else begin
                            r_state <= S_ERD;
                        end
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output word; the physical address exists only when a frame was chosen.
    assign out_phys = (r_res.status == ftcr_pkg::ST_HIT || r_res.status == ftcr_pkg::ST_FREE
                       || r_res.status == ftcr_pkg::ST_VICTIM) ?
                      32'(r_base + 32'(r_ridx) * 32'(PAGE_BYTES)) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_out <= {r_res.status, 6'(r_ridx), out_phys, r_res.evicted_valid,
                      r_res.evicted_page, r_res.evicted_process, r_res.freed_count};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_clr_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLR |-> !o_in_ready)
        else $error("request taken during table clear");

    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("ready right after accepting a request");

    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ERD || r_state == S_EEV) |-> r_steps < r_lim)
        else $error("clock sweep ran past three passes");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && !i_out_ready) |=> r_state == S_OUT)
        else $error("result dropped while output stalled");
endmodule

[tb/tb_frame_table_clock_replacer.sv]
// Testbench of the frame table clock replacer: random and directed requests vs a predictor.
`timescale 1ns / 1ps

module tb_frame_table_clock_replacer;

    localparam int NF = ftcr_pkg::MAX_FRAMES_DEF;
    localparam int PB = ftcr_pkg::PAGE_BYTES_DEF;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [ftcr_pkg::ADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic i_in_valid, o_in_ready;
    ftcr_pkg::t_in i_in;
    logic o_out_valid, i_out_ready;
    ftcr_pkg::t_out o_out;

    frame_table_clock_replacer DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out)
    );

    // Predictor copy of the frame table.
    logic [2:0]  tbl_flags [NF];
    logic [31:0] tbl_page  [NF];
    logic [14:0] tbl_owner [NF];
    int unsigned hand;
    logic [6:0]  cfg_frames;
    logic [31:0] cfg_base;

    ftcr_pkg::t_out expected_words [$];
    int   mismatches;
    bit   send_idle_on;
    bit   recv_idle_on;
    int   recv_hold;
    logic [14:0] pid_pool [4];
    logic [31:0] page_pool [6];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("tb_frame_table_clock_replacer: errors");
        $finish;
    end

    function automatic int unsigned used_frames();
        if (cfg_frames == 0) return 1;
        if (cfg_frames > NF) return NF;
        return cfg_frames;
    endfunction

    function automatic logic [31:0] frame_addr(int unsigned i);
        return cfg_base + 32'(i * PB);
    endfunction

    function automatic int lookup(int unsigned n, logic [31:0] pg, logic [14:0] pid);
        for (int i = 0; i < n; i++)
            if (tbl_flags[i][ftcr_pkg::FL_V] && tbl_page[i] == pg && tbl_owner[i] == pid)
                return i;
        return -1;
    endfunction

    function automatic void take_frame(int unsigned i, logic [31:0] pg, logic [14:0] pid);
        tbl_flags[i][ftcr_pkg::FL_V] = 1'b1;
        tbl_flags[i][ftcr_pkg::FL_T] = 1'b1;
        tbl_page[i] = pg;
        tbl_owner[i] = pid;
    endfunction

    function automatic ftcr_pkg::t_out predict_request(ftcr_pkg::t_in req);
        ftcr_pkg::t_out r;
        int unsigned n, pos, cnt;
        int m;
        logic [2:0] f;
        r = '0;
        r.status = ftcr_pkg::ST_NOTF;
        n = used_frames();
        if (req.opcode == ftcr_pkg::OP_MAP) begin
            m = lookup(n, req.page_address, req.process_id);
            if (m >= 0) begin
                tbl_flags[m][ftcr_pkg::FL_T] = 1'b1;
                r.status = ftcr_pkg::ST_HIT;
                r.frame_index = 6'(m);
                r.phys_address = frame_addr(m);
                return r;
            end
            for (int i = 0; i < n; i++)
                if (!tbl_flags[i][ftcr_pkg::FL_V] && tbl_page[i] != ftcr_pkg::RESERVED_PAGE) begin
                    take_frame(i, req.page_address, req.process_id);
                    r.status = ftcr_pkg::ST_FREE;
                    r.frame_index = 6'(i);
                    r.phys_address = frame_addr(i);
                    return r;
                end
            pos = (hand < n) ? hand : 0;
            for (int s = 0; s < 3 * n; s++) begin
                f = tbl_flags[pos];
                if (!f[ftcr_pkg::FL_T] && tbl_page[pos] != ftcr_pkg::RESERVED_PAGE) begin
                    if (!f[ftcr_pkg::FL_R]) begin
                        if (f[ftcr_pkg::FL_V]) begin
                            r.evicted_valid = 1'b1;
                            r.evicted_page = tbl_page[pos];
                            r.evicted_process = tbl_owner[pos];
                        end
                        take_frame(pos, req.page_address, req.process_id);
                        hand = (pos + 1) % n;
                        r.status = ftcr_pkg::ST_VICTIM;
                        r.frame_index = 6'(pos);
                        r.phys_address = frame_addr(pos);
                        return r;
                    end
                    tbl_flags[pos][ftcr_pkg::FL_R] = 1'b0;
                end
                pos = (pos + 1) % n;
            end
            r.status = ftcr_pkg::ST_NOVIC;
        end else if (req.opcode == ftcr_pkg::OP_REL) begin
            m = lookup(n, req.page_address, req.process_id);
            if (m >= 0) begin
                tbl_flags[m][ftcr_pkg::FL_T] = 1'b0;
                tbl_flags[m][ftcr_pkg::FL_R] = 1'b1;
                r.status = ftcr_pkg::ST_HIT;
                r.frame_index = 6'(m);
                r.phys_address = frame_addr(m);
            end
        end else if (req.opcode == ftcr_pkg::OP_FREE) begin
            cnt = 0;
            for (int i = 0; i < n; i++)
                if (tbl_flags[i][ftcr_pkg::FL_V] && tbl_owner[i] == req.process_id &&
                    tbl_page[i] != ftcr_pkg::RESERVED_PAGE) begin
                    tbl_flags[i] = '0;
                    tbl_page[i] = '0;
                    tbl_owner[i] = '0;
                    cnt++;
                end
            r.status = ftcr_pkg::ST_FREED;
            r.freed_count = (cnt > 127) ? ftcr_pkg::CNT_MAX : 7'(cnt);
        end
        return r;
    endfunction

    // The block is never ready the cycle after it takes a word, so waiting for a clock edge
    // before driving the next one costs nothing and keeps valid from being driven twice at one edge.
    task automatic send_request(logic [1:0] op, logic [31:0] pg, logic [14:0] pid);
        ftcr_pkg::t_in req;
        req.opcode = op;
        req.page_address = pg;
        req.process_id = pid;
        @(posedge i_clk);
        while (send_idle_on && $urandom_range(99) < 20) @(posedge i_clk);
        i_in_valid <= 1'b1;
        i_in <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_words.push_back(predict_request(req));
        i_in_valid <= 1'b0;
    endtask

    task automatic drain_results();
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic write_register(logic [ftcr_pkg::ADDR_W-1:0] addr, logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ftcr_pkg::ADDR_AF) cfg_frames = value[6:0];
        else cfg_base = value;
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result word %h", o_out);
                end else begin
                    ftcr_pkg::t_out e;
                    e = expected_words.pop_front();
                    if (o_out !== e) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %h actual %h (st %0d/%0d idx %0d/%0d)",
                                     e, o_out, e.status, o_out.status,
                                     e.frame_index, o_out.frame_index);
                    end
                end
            end
        end
    end

    // Receiver: random idling, plus a long hold counted down cycle by cycle.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (recv_hold > 0) begin
                recv_hold--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= !(recv_idle_on && $urandom_range(99) < 20);
            end
        end
    end

    function automatic logic [14:0] pick_pid();
        return ($urandom_range(9) == 0) ? 15'($urandom) : pid_pool[$urandom_range(3)];
    endfunction

    function automatic logic [31:0] pick_page();
        return ($urandom_range(9) == 0) ? $urandom : page_pool[$urandom_range(5)];
    endfunction

    task automatic test_directed();
        send_request(ftcr_pkg::OP_REL, 32'h1234, 15'd5);
        send_request(ftcr_pkg::OP_MAP, 32'hFFFF_FFFF, 15'h7FFF);
        send_request(ftcr_pkg::OP_MAP, 32'hFFFF_FFFF, 15'h7FFF);
        send_request(ftcr_pkg::OP_MAP, 32'h0, 15'h0);
        send_request(ftcr_pkg::OP_MAP, ftcr_pkg::RESERVED_PAGE, 15'd3);
        send_request(ftcr_pkg::OP_MAP, 32'h5555_AAAA, 15'h2AAA);
        send_request(ftcr_pkg::OP_REL, 32'hFFFF_FFFF, 15'h7FFF);
        send_request(ftcr_pkg::OP_REL, 32'hFFFF_FFFF, 15'h7FFF);
        send_request(ftcr_pkg::OP_UNDEF, 32'hAAAA_5555, 15'h5555);
        send_request(ftcr_pkg::OP_FREE, 32'h0, 15'd3);
        send_request(ftcr_pkg::OP_FREE, 32'h0, 15'h7FFF);
        send_request(ftcr_pkg::OP_FREE, 32'h0, 15'd99);
        drain_results();
        // Small table: fill it, then force sweeps and a no-victim case.
        write_register(ftcr_pkg::ADDR_AF, 32'd2);
        write_register(ftcr_pkg::ADDR_BASE, 32'hFFFF_F000);
        send_request(ftcr_pkg::OP_MAP, 32'h10, 15'd1);
        send_request(ftcr_pkg::OP_MAP, 32'h20, 15'd1);
        send_request(ftcr_pkg::OP_MAP, 32'h30, 15'd1);
        send_request(ftcr_pkg::OP_REL, 32'h10, 15'd1);
        send_request(ftcr_pkg::OP_MAP, 32'h40, 15'd2);
        send_request(ftcr_pkg::OP_REL, 32'h20, 15'd1);
        send_request(ftcr_pkg::OP_REL, 32'h40, 15'd2);
        send_request(ftcr_pkg::OP_MAP, 32'h50, 15'd2);
        send_request(ftcr_pkg::OP_MAP, 32'h60, 15'd2);
        send_request(ftcr_pkg::OP_FREE, 32'h0, 15'd2);
        drain_results();
    endtask

    task automatic test_random(int count, int frames);
        write_register(ftcr_pkg::ADDR_AF, 32'(frames));
        write_register(ftcr_pkg::ADDR_BASE, $urandom);
        for (int i = 0; i < count; i++) begin
            int k;
            k = $urandom_range(99);
            if (k < 55) send_request(ftcr_pkg::OP_MAP, pick_page(), pick_pid());
            else if (k < 85) send_request(ftcr_pkg::OP_REL, pick_page(), pick_pid());
            else if (k < 96) send_request(ftcr_pkg::OP_FREE, $urandom, pick_pid());
            else send_request(ftcr_pkg::OP_UNDEF, $urandom, 15'($urandom));
        end
        drain_results();
    endtask

    task automatic test_backpressure();
        recv_hold = 400;
        for (int i = 0; i < 12; i++) send_request(ftcr_pkg::OP_MAP, pick_page(), pick_pid());
        drain_results();
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        for (int i = 0; i < 30; i++) send_request(ftcr_pkg::OP_REL, pick_page(), pick_pid());
        drain_results();
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        i_in_valid = 1'b0; i_in = '0; i_out_ready = 1'b0;
        for (int i = 0; i < NF; i++) begin
            tbl_flags[i] = '0; tbl_page[i] = '0; tbl_owner[i] = '0;
        end
        hand = 0; cfg_frames = ftcr_pkg::AF_RESET; cfg_base = '0;
        mismatches = 0; recv_hold = 0;
        send_idle_on = 1'b1; recv_idle_on = 1'b1;
        for (int i = 0; i < 4; i++) pid_pool[i] = 15'($urandom);
        for (int i = 0; i < 6; i++)
            page_pool[i] = (i == 0) ? ftcr_pkg::RESERVED_PAGE : $urandom;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(120, 4);
        test_random(60, 1);
        test_random(100, 8);
        test_backpressure();
        test_random(60, 64);
        test_random(30, 0);
        test_random(20, 127);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("tb_frame_table_clock_replacer: clean");
        end else begin
            $display("tb_frame_table_clock_replacer: errors");
        end
        $finish;
    end
endmodule

[files.f]
hw/rtl/ftcr_pkg.sv
hw/rtl/ftcr_cmp.sv
hw/rtl/ftcr_mem.sv
hw/rtl/frame_table_clock_replacer.sv
tb/tb_frame_table_clock_replacer.sv
